>>> design/tpss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpss_pkg: shared types and constants for the touch pen sample sequencer
// Field widths, command and mode codes, and the item and result structs.
// ----------------------------------------------------------------------------
package tpss_pkg;

    // Number of X/Y pairs summed per press, and sample width kept
    localparam int SAMPLES     = 4;
    localparam int SAMPLE_BITS = 10;

    localparam int SMP_W = 10;                       // conversion field width
    localparam int ACC_W = 12;                       // accumulator / event width
    localparam int CNT_W = $clog2(SAMPLES + 1);      // counts up to SAMPLES

    localparam logic [SMP_W-1:0] SAMPLE_MASK = SMP_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [CNT_W-1:0] SAMPLE_LAST = CNT_W'(SAMPLES);

    // Stream widths: payload packed from bit 0, padded to whole bytes
    localparam int IN_DATA_BITS  = 1 + 2 * SMP_W;
    localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = 2 + 1 + 1 + 2 * ACC_W + 1;
    localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        CMD_PEN_IRQ  = 2'd0,
        CMD_ADC_DONE = 2'd1,
        CMD_READ     = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_WAIT_DOWN = 2'd0,
        MODE_AUTO      = 2'd1,
        MODE_WAIT_UP   = 2'd2,
        MODE_KEEP      = 2'd3
    } mode_t;

    typedef struct packed {
        cmd_t             command;
        logic             pen_up;
        logic [SMP_W-1:0] x_sample;
        logic [SMP_W-1:0] y_sample;
    } item_t;

    typedef struct packed {
        mode_t            panel_mode;
        logic             start_conversion;
        logic             event_valid;
        logic             event_press;
        logic [ACC_W-1:0] event_x;
        logic [ACC_W-1:0] event_y;
        logic             readable;
    } result_t;

endpackage
`default_nettype wire

>>> design/tpss_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpss_in_reg: input register
// Captures one command transaction; holds it until the core consumes it.
// ----------------------------------------------------------------------------
module tpss_in_reg
    import tpss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  wire logic [1:0]            s_axis_tuser,
    input  wire logic                  advance,
    output logic                       item_valid,
    output item_t                      item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_axis_tready = !valid_reg || advance;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.command  <= cmd_t'(s_axis_tuser);
            item_reg.pen_up   <= s_axis_tdata[0];
            item_reg.x_sample <= s_axis_tdata[SMP_W:1];
            item_reg.y_sample <= s_axis_tdata[2*SMP_W:SMP_W+1];
        end
    end

endmodule
`default_nettype wire

>>> design/tpss_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpss_core: sequencer state and per-command step logic
// Holds ADC ownership, accumulators, latched sums and pending events.
// ----------------------------------------------------------------------------
module tpss_core
    import tpss_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  fire,
    input  wire item_t item,
    output result_t    result
);

    logic             adc_owned_reg,       adc_owned_next;
    logic [CNT_W-1:0] sample_count_reg,    sample_count_next;
    logic [ACC_W-1:0] x_accum_reg,         x_accum_next;
    logic [ACC_W-1:0] y_accum_reg,         y_accum_next;
    logic [ACC_W-1:0] x_latched_reg,       x_latched_next;
    logic [ACC_W-1:0] y_latched_reg,       y_latched_next;
    logic             press_pending_reg,   press_pending_next;
    logic             release_pending_reg, release_pending_next;

    logic [ACC_W-1:0] x_sum;
    logic [ACC_W-1:0] y_sum;
    logic [CNT_W-1:0] count_inc;

    assign x_sum     = x_accum_reg + {{(ACC_W-SMP_W){1'b0}}, item.x_sample & SAMPLE_MASK};
    assign y_sum     = y_accum_reg + {{(ACC_W-SMP_W){1'b0}}, item.y_sample & SAMPLE_MASK};
    assign count_inc = sample_count_reg + 1'b1;

    always_comb
    begin
        adc_owned_next       = adc_owned_reg;
        sample_count_next    = sample_count_reg;
        x_accum_next         = x_accum_reg;
        y_accum_next         = y_accum_reg;
        x_latched_next       = x_latched_reg;
        y_latched_next       = y_latched_reg;
        press_pending_next   = press_pending_reg;
        release_pending_next = release_pending_reg;

        result.panel_mode       = MODE_KEEP;
        result.start_conversion = 1'b0;
        result.event_valid      = 1'b0;
        result.event_press      = 1'b0;
        result.event_x          = '0;
        result.event_y          = '0;

        case (item.command)
            CMD_PEN_IRQ:
            begin
                if (!item.pen_up)
                begin
                    adc_owned_next          = 1'b1;
                    result.panel_mode       = MODE_AUTO;
                    result.start_conversion = 1'b1;
                end
                else
                begin
                    adc_owned_next       = 1'b0;
                    release_pending_next = 1'b1;
                    sample_count_next    = '0;
                    x_accum_next         = '0;
                    y_accum_next         = '0;
                    result.panel_mode    = MODE_WAIT_DOWN;
                end
            end
            CMD_ADC_DONE:
            begin
                if (adc_owned_reg && (sample_count_reg < SAMPLE_LAST))
                begin
                    if (count_inc < SAMPLE_LAST)
                    begin
                        sample_count_next       = count_inc;
                        x_accum_next            = x_sum;
                        y_accum_next            = y_sum;
                        result.panel_mode       = MODE_AUTO;
                        result.start_conversion = 1'b1;
                    end
                    else
                    begin
                        // last pair: latch sums, raise press, restart accumulation
                        x_latched_next     = x_sum;
                        y_latched_next     = y_sum;
                        press_pending_next = 1'b1;
                        sample_count_next  = '0;
                        x_accum_next       = '0;
                        y_accum_next       = '0;
                        result.panel_mode  = MODE_WAIT_UP;
                    end
                end
            end
            CMD_READ:
            begin
                if (press_pending_reg)
                begin
                    press_pending_next = 1'b0;
                    result.event_valid = 1'b1;
                    result.event_press = 1'b1;
                    result.event_x     = x_latched_reg;
                    result.event_y     = y_latched_reg;
                end
                else if (release_pending_reg)
                begin
                    release_pending_next = 1'b0;
                    result.event_valid   = 1'b1;
                    result.event_x       = x_latched_reg;
                    result.event_y       = y_latched_reg;
                end
            end
            default:
            begin
            end
        endcase

        result.readable = press_pending_next || release_pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adc_owned_reg       <= 1'b0;
            sample_count_reg    <= '0;
            x_accum_reg         <= '0;
            y_accum_reg         <= '0;
            x_latched_reg       <= '0;
            y_latched_reg       <= '0;
            press_pending_reg   <= 1'b0;
            release_pending_reg <= 1'b0;
        end
        else if (fire)
        begin
            adc_owned_reg       <= adc_owned_next;
            sample_count_reg    <= sample_count_next;
            x_accum_reg         <= x_accum_next;
            y_accum_reg         <= y_accum_next;
            x_latched_reg       <= x_latched_next;
            y_latched_reg       <= y_latched_next;
            press_pending_reg   <= press_pending_next;
            release_pending_reg <= release_pending_next;
        end
    end

endmodule
`default_nettype wire

>>> design/tpss_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpss_out_reg: result register
// Holds one result transaction until the master side takes it.
// ----------------------------------------------------------------------------
module tpss_out_reg
    import tpss_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire result_t                result,
    output logic                        free,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tuser
);

    logic    valid_reg;
    result_t result_reg;

    assign free          = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = result_reg.event_press;
    assign m_axis_tdata  = {
        (OUT_TDATA_W - OUT_DATA_BITS)'(0),
        result_reg.readable,
        result_reg.event_y,
        result_reg.event_x,
        result_reg.event_valid,
        result_reg.start_conversion,
        result_reg.panel_mode
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule
`default_nettype wire

>>> design/touch_pen_sample_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_pen_sample_sequencer: resistive touch panel sample sequencer
// Pen interrupts, ADC completions and event reads in; one result per command.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata                                         tuser
//  --------  ---  --------------------------------------------  -----------
//  s_axis    in   [0] pen_up [10:1] x_sample [20:11] y_sample   command
//  m_axis    out  [1:0] panel_mode [2] start_conversion         event_press
//                 [3] event_valid [15:4] event_x
//                 [27:16] event_y [28] readable
//
//  Every command transaction yields exactly one result transaction.
//  Commands pass through the input register, then the step logic into the result
//  register. Throughput is one transaction per cycle while the result side is not
//  stalled; the step is a 12-bit add pair plus a small counter compare.
//  Reset (rst_n low, async) clears ownership, counters, sums and events.
//  A stalled result holds the result register; one more command waits in
//  the input register before s_axis_tready drops.
//
module touch_pen_sample_sequencer
    import tpss_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // pen_up, x_sample, y_sample
    input  wire logic [1:0]             s_axis_tuser,   // command
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // panel_mode, start_conversion,
                                                        // event_valid, event_x, event_y,
                                                        // readable
    output logic                        m_axis_tuser    // event_press
);

    logic    item_valid;
    item_t   item;
    result_t result;
    logic    out_free;
    logic    advance;

    // item moves from the input register into the result register
    assign advance = item_valid && out_free;

    tpss_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    // state commits in the same cycle the result is loaded
    tpss_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item),
        .result (result)
    );

    tpss_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .result        (result),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

`ifndef SYNTH
    // a held command behind a stalled result must block the slave side
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("slave ready while both stages are full");

    // a command that advances shows up as a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("advanced command produced no result");

    // an accepted command is held in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> item_valid)
        else $error("accepted command lost");

    // a returned event never carries a mode change
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[3]) |-> (m_axis_tdata[1:0] == MODE_KEEP))
        else $error("event result with mode change");
`endif

endmodule
`default_nettype wire
